FILE: rtl/core/dst_pkg.sv
// ----------------------------------------------------------------------------
// dst_pkg
// Shared widths, register map and types for the delimiter string tokenizer.
// ----------------------------------------------------------------------------
package dst_pkg;

    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CNT_W      = 4;
    localparam int DELIM_W    = 64;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_DELIM_CHARS = 2'd0,
        REG_DELIM_COUNT = 2'd1,
        REG_STRICT_MODE = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              has_char;
        logic              token_end;
        logic              string_end;
    } t_tok_result;

endpackage

FILE: rtl/core/dst_match.sv
// ----------------------------------------------------------------------------
// dst_match
// Parallel compare of one byte against the configured delimiter set.
// ----------------------------------------------------------------------------
module dst_match #(
    parameter int MAX_DELIMITERS = 8
) (
    input  logic [dst_pkg::CHAR_W-1:0]  i_char,
    input  logic [dst_pkg::DELIM_W-1:0] i_delim_chars,
    input  logic [dst_pkg::CNT_W-1:0]   i_delim_count,
    output logic                        o_hit
);
    import dst_pkg::*;

    logic [CNT_W-1:0]          n_lanes;
    logic [MAX_DELIMITERS-1:0] lane_hit;

    // counts above the lane count are clamped
    assign n_lanes = (i_delim_count > CNT_W'(MAX_DELIMITERS)) ?
                     CNT_W'(MAX_DELIMITERS) : i_delim_count;

    for (genvar k = 0; k < MAX_DELIMITERS; k++) begin : g_lane
        assign lane_hit[k] = (CNT_W'(k) < n_lanes) &&
                             (i_delim_chars[k*CHAR_W +: CHAR_W] == i_char);
    end

    assign o_hit = |lane_hit;

endmodule

FILE: rtl/core/delimiter_string_tokenizer.sv
// ----------------------------------------------------------------------------
// delimiter_string_tokenizer
// Splits a byte stream into tokens at up to eight configured delimiter bytes.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   tvalid/tready           tdata[7:0] = char_value
// m_axis    out  tvalid/tready           tdata[7:0] = out_char, tlast = token_end,
//                                        tuser[0] = has_char, tuser[1] = string_end
// apb       in   psel/penable/pready     regs at 0x00 chars, 0x08 count, 0x10 strict
//
// one byte per cycle while m_axis is not stalled; a byte's result shows in the cycle after it is taken
// the delimiter compare is a single parallel stage ahead of the result register
// s_axis_tready stays high while the result register is empty or being drained
// delimiter bytes produce no word in loose mode when no token is open
// synchronous active-low reset clears the config registers, token state and valid
// ----------------------------------------------------------------------------
module delimiter_string_tokenizer #(
    parameter int MAX_DELIMITERS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] char_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] out_char
    output logic                           m_axis_tlast,
    output logic [1:0]                     m_axis_tuser,  // [0] has_char, [1] string_end
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dst_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [dst_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [dst_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import dst_pkg::*;

    logic [DELIM_W-1:0] r_delim_chars;
    logic [CNT_W-1:0]   r_delim_count;
    logic               r_strict;
    logic               r_token_open;
    logic               n_token_open;
    logic               r_out_valid;
    t_tok_result        r_out;
    t_tok_result        n_out;
    logic               n_emit;
    logic               in_fire;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    logic               delim_hit;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_chars <= '0;
            r_delim_count <= '0;
            r_strict      <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DELIM_CHARS: r_delim_chars <= pwdata[DELIM_W-1:0];
                REG_DELIM_COUNT: r_delim_count <= pwdata[CNT_W-1:0];
                REG_STRICT_MODE: r_strict      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DELIM_CHARS: prdata = r_delim_chars;
            REG_DELIM_COUNT: prdata = CFG_DATA_W'(r_delim_count);
            REG_STRICT_MODE: prdata = CFG_DATA_W'(r_strict);
            default:         prdata = '0;
        endcase
    end

    // ---------------- tokenizer ----------------
    dst_match #(
        .MAX_DELIMITERS (MAX_DELIMITERS)
    ) u_match (
        .i_char        (s_axis_tdata),
        .i_delim_chars (r_delim_chars),
        .i_delim_count (r_delim_count),
        .o_hit         (delim_hit)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_out        = '0;
        n_emit       = 1'b0;
        n_token_open = r_token_open;
        priority if (s_axis_tdata == '0) begin
            // terminator wins even if zero is in the set
            n_emit           = 1'b1;
            n_out.token_end  = r_strict || r_token_open;
            n_out.string_end = 1'b1;
            n_token_open     = 1'b0;
        end else if (delim_hit) begin
            n_emit          = r_strict || r_token_open;
            n_out.token_end = 1'b1;
            n_token_open    = 1'b0;
        end else begin
            n_emit         = 1'b1;
            n_out.out_char = s_axis_tdata;
            n_out.has_char = 1'b1;
            n_token_open   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_open <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_token_open <= n_token_open;
                r_out_valid  <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_char;
    assign m_axis_tlast  = r_out.token_end;
    assign m_axis_tuser  = {r_out.string_end, r_out.has_char};

    // ---------------- assertions ----------------
    a_term_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tdata == '0) |=> (!r_token_open && r_out_valid && r_out.string_end))
        else $error("terminator did not close the string");

    a_char_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tdata != '0 && !delim_hit)
        |=> (r_token_open && r_out_valid && r_out.has_char && r_out.out_char == $past(s_axis_tdata)))
        else $error("token character lost");

    a_char_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.has_char) |-> (!r_out.token_end && !r_out.string_end))
        else $error("character word also flags an end");

    a_end_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.has_char) |-> (r_out.out_char == '0))
        else $error("end word carries a character");

endmodule

FILE: bench/delimiter_string_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimiter_string_tokenizer_tb
// Stream and register bench for the delimiter string tokenizer: bytes go in
// through s_axis under random gaps, every word out of m_axis is checked field
// by field against an in-bench tokenizer that tracks the open-token flag.
// ----------------------------------------------------------------------------
module delimiter_string_tokenizer_tb;
    import dst_pkg::*;

    localparam int  MAX_DELIM     = 8;
    localparam int  SETTLE_CYCLES = 6;
    localparam int  RANDOM_BYTES  = 1030;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;   // [7:0] char_value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [7:0] out_char
    logic                  m_axis_tlast;
    logic [1:0]            m_axis_tuser;        // [0] has_char, [1] string_end
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // tokenizer state and register copy
    logic [63:0]   delim_set = '0;
    logic [3:0]    delim_cnt = '0;
    logic          strict_on = 1'b0;
    logic          token_open = 1'b0;

    logic [7:0]    char_queue[$];
    t_tok_result   expected_tokens[$];

    int   src_wait = 0;
    int   sink_wait = 0;
    bit   src_quiet = 1'b0;
    bit   sink_quiet = 1'b0;
    int   errors = 0;
    int   bytes_queued = 0;
    int   words_checked = 0;
    int   chars_seen = 0;
    int   ends_seen = 0;
    int   strings_seen = 0;
    int   cfg_phases = 0;
    int   strict_phases = 0;

    delimiter_string_tokenizer #(.MAX_DELIMITERS(MAX_DELIM)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic int active_delims();
        return (delim_cnt > MAX_DELIM) ? MAX_DELIM : int'(delim_cnt);
    endfunction

    // returns 1 when the byte yields a word; updates the open-token flag
    function automatic bit tokenize_byte(input logic [7:0] ch, output t_tok_result res);
        bit is_delim;
        is_delim = 1'b0;
        res = '0;
        for (int k = 0; k < MAX_DELIM; k++)
            if (k < active_delims() && delim_set[8*k +: 8] == ch)
                is_delim = 1'b1;
        if (ch == 8'h00) begin
            res.string_end = 1'b1;
            res.token_end  = strict_on | token_open;
            token_open = 1'b0;
            return 1'b1;
        end
        if (is_delim) begin
            if (strict_on || token_open) begin
                res.token_end = 1'b1;
                token_open = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        res.out_char = ch;
        res.has_char = 1'b1;
        token_open = 1'b1;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                src_wait--;
            end else if (char_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= char_queue.pop_front();
                src_wait = draw_wait(src_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predicts on accepted bytes, checks accepted words
    always @(posedge i_clk) begin
        t_tok_result res;
        t_tok_result exp_res;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait = 0;
            token_open = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                if (tokenize_byte(s_axis_tdata, res))
                    expected_tokens.push_back(res);
            if (m_axis_tvalid && m_axis_tready) begin
                words_checked++;
                if (m_axis_tuser[0]) chars_seen++;
                if (m_axis_tlast) ends_seen++;
                if (m_axis_tuser[1]) strings_seen++;
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got char %0h last %0b user %0b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    exp_res = expected_tokens.pop_front();
                    check_field("out_char", exp_res.out_char, m_axis_tdata);
                    check_field("has_char", exp_res.has_char, m_axis_tuser[0]);
                    check_field("token_end", exp_res.token_end, m_axis_tlast);
                    check_field("string_end", exp_res.string_end, m_axis_tuser[1]);
                end
                sink_wait = draw_wait(sink_quiet);
            end
            if (sink_wait > 0) begin
                m_axis_tready <= 1'b0;
                sink_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DELIM_CHARS: delim_set = value;
            REG_DELIM_COUNT: delim_cnt = value[3:0];
            REG_STRICT_MODE: strict_on = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] chars, input logic [3:0] cnt, input bit strict);
        cfg_write(REG_DELIM_CHARS, chars);
        cfg_write(REG_DELIM_COUNT, {60'd0, cnt});
        cfg_write(REG_STRICT_MODE, {63'd0, strict});
        cfg_phases++;
        if (strict) strict_phases++;
    endtask

    // no word for skipped delimiters, so give the pipe a settling wait after the last word
    task automatic wait_drained();
        do @(negedge i_clk);
        while (char_queue.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_bytes(input logic [7:0] seq[]);
        foreach (seq[i]) char_queue.push_back(seq[i]);
        bytes_queued += seq.size();
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = active_delims();
        if (r < 35 && n > 0)
            return delim_set[8*$urandom_range(0, n-1) +: 8];
        if (r < 40)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // mostly terminated strings with mixed delimiters, some raw noise
    task automatic queue_strings(input int budget);
        int len;
        while (budget > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                char_queue.push_back(8'($urandom_range(0, 255)));
                budget--;
            end else begin
                len = $urandom_range(0, 12);
                repeat (len) char_queue.push_back(pick_byte());
                budget -= len;
                // sometimes leave the string open across a register change
                if (budget > 0 || $urandom_range(0, 1)) begin
                    char_queue.push_back(8'h00);
                    budget--;
                end
            end
        end
        bytes_queued = bytes_queued + 0;
    endtask

    initial begin
        logic [63:0] chars;
        int          budget;
        int          start_len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: no delimiters, loose
        queue_bytes('{8'h41, 8'hFF, 8'h00, 8'h00});
        wait_drained();

        // zero byte and 0xff in the active set, 0x01 just past the count
        set_config(64'h2D3A7F01_FF00202C, 4'd4, 1'b0);
        queue_bytes('{8'h2C, 8'h2C, 8'h61, 8'h2C, 8'h62, 8'h20, 8'h20, 8'h63,
                      8'h01, 8'hFF, 8'h00, 8'h61});
        wait_drained();

        // strict from here with the token above still open
        cfg_write(REG_STRICT_MODE, 64'd1);
        strict_phases++;
        queue_bytes('{8'h2C, 8'h2C, 8'h62, 8'h00, 8'h00});
        wait_drained();

        // oversized count clamps to eight lanes
        set_config(64'h2D3A7F01_FF00202C, 4'd15, 1'b0);
        queue_bytes('{8'h61, 8'h2D, 8'h00});
        wait_drained();

        budget = RANDOM_BYTES;
        while (budget > 0) begin
            case ($urandom_range(0, 4))
                0: chars = '0;
                1: chars = '1;
                default: chars = {$urandom, $urandom};
            endcase
            set_config(chars, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            start_len = char_queue.size();
            queue_strings((budget < 90) ? budget : 90);
            bytes_queued += char_queue.size() - start_len;
            budget -= char_queue.size() - start_len;
            wait_drained();
        end

        $display("covered %0d bytes over %0d register settings (%0d strict)",
                 bytes_queued, cfg_phases, strict_phases);
        $display("checked %0d words: %0d chars, %0d token ends, %0d string ends",
                 words_checked, chars_seen, ends_seen, strings_seen);
        if (errors == 0) begin
            $display("delimiter_string_tokenizer regression: pass");
        end else begin
            $display("delimiter_string_tokenizer regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d words still expected", expected_tokens.size());
        $display("delimiter_string_tokenizer regression: fail");
        $finish;
    end

endmodule
